/* rtl/tarc_pkg.sv */
// Shared types and constants for the three-axis high-pass and low-pass filter.
`timescale 1ns / 1ps

package tarc_pkg;

    localparam int SAMPLE_BITS = 14;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_BITS   = 16;
    localparam int OUT_BITS    = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int SUM_BITS    = OUT_BITS + 2;
    localparam int PROD_BITS   = SUM_BITS + COEF_BITS + 1;
    localparam int CFG_INDEX_BITS = 4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    value_t;
    typedef logic        [COEF_BITS-1:0]   coef_t;
    typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t CFG_HIGH_PASS_COEF = cfg_index_t'(0);
    localparam cfg_index_t CFG_LOW_PASS_COEF  = cfg_index_t'(1);

    localparam coef_t HIGH_PASS_COEF_RESET = coef_t'(32768);
    localparam coef_t LOW_PASS_COEF_RESET  = coef_t'(32768);

    // Control handed from the top level to each axis filter.
    typedef struct packed {
        logic  update;
        coef_t hp_coef;
        coef_t lp_coef;
    } tarc_ctrl_t;

endpackage

/* rtl/tarc_ifs.sv */
// Stream and configuration interfaces of the three-axis filter.
`timescale 1ns / 1ps

interface tarc_sample_if import tarc_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_x;
    sample_t sample_y;
    sample_t sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tarc_result_if import tarc_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t hp_x;
    value_t hp_y;
    value_t hp_z;
    value_t lp_x;
    value_t lp_y;
    value_t lp_z;

    modport source (output valid, output hp_x, output hp_y, output hp_z,
                    output lp_x, output lp_y, output lp_z, input ready);
    modport sink (input valid, input hp_x, input hp_y, input hp_z,
                  input lp_x, input lp_y, input lp_z, output ready);
endinterface

interface tarc_cfg_if import tarc_pkg::*; ();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    coef_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/three_axis_rc_high_low_pass.sv */
// Top level of the three-axis high-pass and low-pass accelerometer filter.
`timescale 1ns / 1ps

// Takes one request of three signed 14-bit samples per cycle while results are taken and
// returns one result of six 23-bit values (8 fraction bits) per request, held in the
// result register. A request is held in an input register; when the result register is
// free or being taken, all three axes update their filter state together, which sets the
// rate of one request per cycle: each axis loop is an add, a 25 by 17 bit multiply and a
// clamp. The filter state itself is the result register. Coefficients are Q0.16 and are
// written through the configuration channel, which is always ready; write them only while
// no request is in flight.
module three_axis_rc_high_low_pass import tarc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tarc_cfg_if.sink      cfg,
    tarc_sample_if.sink   samples,
    tarc_result_if.source results
);

    coef_t   hp_coef_reg;
    coef_t   hp_coef_next;
    coef_t   lp_coef_reg;
    coef_t   lp_coef_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t x_reg;
    sample_t y_reg;
    sample_t z_reg;
    logic    advance;
    logic    accept;
    tarc_ctrl_t ctrl;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        hp_coef_next = hp_coef_reg;
        lp_coef_next = lp_coef_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HIGH_PASS_COEF: hp_coef_next = cfg.data;
                CFG_LOW_PASS_COEF:  lp_coef_next = cfg.data;
                default:            ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_coef_reg   <= HIGH_PASS_COEF_RESET;
            lp_coef_reg   <= LOW_PASS_COEF_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hp_coef_reg   <= hp_coef_next;
            lp_coef_reg   <= lp_coef_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= samples.sample_x;
            y_reg <= samples.sample_y;
            z_reg <= samples.sample_z;
        end
    end

    assign ctrl.update  = advance;
    assign ctrl.hp_coef = hp_coef_reg;
    assign ctrl.lp_coef = lp_coef_reg;

    tarc_axis u_axis_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (x_reg),
        .hp     (results.hp_x),
        .lp     (results.lp_x)
    );

    tarc_axis u_axis_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (y_reg),
        .hp     (results.hp_y),
        .lp     (results.lp_y)
    );

    tarc_axis u_axis_z
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (z_reg),
        .hp     (results.hp_z),
        .lp     (results.lp_z)
    );

    assign results.valid = out_valid_reg;

    // The filter state doubles as the result, so it must not move while a result waits.
    a_no_update_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !ctrl.update)
        else $error("filter state updated while a result was stalled");

    a_update_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |=> out_valid_reg)
        else $error("state update did not present a result");

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted request was not held in the input register");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !results.ready |-> !samples.ready)
        else $error("request accepted while both stages were full and stalled");

endmodule

/* rtl/tarc_axis.sv */
// One axis: first-order high-pass and low-pass filter with its state registers.
`timescale 1ns / 1ps

module tarc_axis import tarc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tarc_ctrl_t ctrl,
    input  sample_t    sample,
    output value_t     hp,
    output value_t     lp
);

    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS:0]    scaled_t;

    sample_t prev_reg;
    value_t  hp_reg;
    value_t  lp_reg;
    value_t  hp_next;
    value_t  lp_next;

    logic signed [SAMPLE_BITS:0] diff;
    sum_t    hp_sum;
    sum_t    cur_f;
    sum_t    lp_diff;
    prod_t   hp_prod;
    prod_t   lp_prod;
    scaled_t hp_scaled;
    scaled_t lp_scaled;
    logic    hp_ovf;

    assign diff    = {sample[SAMPLE_BITS-1], sample} - {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign hp_sum  = sum_t'(hp_reg) + (sum_t'(diff) <<< FRAC_BITS);
    assign hp_prod = prod_t'(hp_sum) * prod_t'($signed({1'b0, ctrl.hp_coef}));
    // Dropping the low bits of a two's complement product rounds toward minus infinity.
    assign hp_scaled = hp_prod[PROD_BITS-1:COEF_BITS];
    assign hp_ovf    = (hp_scaled[SUM_BITS:OUT_BITS-1] != '0)
                    && (hp_scaled[SUM_BITS:OUT_BITS-1] != '1);

    always_comb
    begin
        if (hp_ovf)
        begin
            hp_next = hp_scaled[SUM_BITS] ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                          : {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        else
        begin
            hp_next = hp_scaled[OUT_BITS-1:0];
        end
    end

    // The low-pass step lands between the old value and the sample, so it needs no clamp.
    assign cur_f     = sum_t'(sample) <<< FRAC_BITS;
    assign lp_diff   = cur_f - sum_t'(lp_reg);
    assign lp_prod   = prod_t'(lp_diff) * prod_t'($signed({1'b0, ctrl.lp_coef}));
    assign lp_scaled = lp_prod[PROD_BITS-1:COEF_BITS];
    assign lp_next   = lp_reg + lp_scaled[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            hp_reg   <= '0;
            lp_reg   <= '0;
        end
        else if (ctrl.update)
        begin
            prev_reg <= sample;
            hp_reg   <= hp_next;
            lp_reg   <= lp_next;
        end
    end

    assign hp = hp_reg;
    assign lp = lp_reg;

endmodule

/* test/tb_three_axis_rc_high_low_pass.sv */
// Self-checking testbench of the three-axis high-pass and low-pass filter.
`timescale 1ns / 1ps

module tb_three_axis_rc_high_low_pass;
    import tarc_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RESET_CYCLES     = 11;
    localparam int CHUNKS_PER_PHASE = 7;
    localparam int CHUNK_ITEMS      = 40;
    localparam int MAX_PRINTED      = 50;

    localparam longint VALUE_MAX = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    localparam cfg_index_t CFG_FIRST_UNUSED = CFG_LOW_PASS_COEF + cfg_index_t'(1);
    localparam cfg_index_t CFG_LAST_UNUSED  = '1;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam sample_t SAMPLE_NEG1 = '1;
    localparam coef_t   COEF_MAX = '1;

    typedef struct packed {
        value_t hp_x;
        value_t hp_y;
        value_t hp_z;
        value_t lp_x;
        value_t lp_y;
        value_t lp_z;
    } filter_out_t;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_index_t  index;
        coef_t       data;
        sample_t     x;
        sample_t     y;
        sample_t     z;
        bit          checked;
        filter_out_t want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tarc_cfg_if    cfg_if ();
    tarc_sample_if sample_if ();
    tarc_result_if result_if ();

    three_axis_rc_high_low_pass dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .samples (sample_if),
        .results (result_if)
    );

    always #5 clk = ~clk;

    // Filter model state and its copy of the coefficients.
    value_t  hp_state [3];
    value_t  lp_state [3];
    sample_t prev_state [3];
    coef_t   hp_coef_model = HIGH_PASS_COEF_RESET;
    coef_t   lp_coef_model = LOW_PASS_COEF_RESET;

    filter_out_t due_filtered [$];
    stim_row_t   stim_rows [$];
    sample_t     walk [3];

    int errors         = 0;
    int result_count   = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 27;
    int recv_stall_pct = 81;
    bit sample_held    = 1'b0;
    bit cfg_held       = 1'b0;

    string       field_names [6] = '{"hp_x", "hp_y", "hp_z", "lp_x", "lp_y", "lp_z"};
    value_t      got_fields [6];
    value_t      want_fields [6];
    filter_out_t want_now;

    task automatic report_error(string msg);
        if (errors < MAX_PRINTED)
            $display("ERROR: %s", msg);
        errors++;
    endtask

    // floor(x * c / 2^COEF_BITS)
    function automatic longint coef_product(longint x, coef_t c);
        longint cl;
        cl = {{(64 - COEF_BITS){1'b0}}, c};
        return (x * cl) >>> COEF_BITS;
    endfunction

    function automatic void step_axis(input int a, input sample_t cur,
                                      output value_t hp_o, output value_t lp_o);
        longint cur_f;
        longint prev_f;
        longint hp_new;
        longint lp_old;
        cur_f  = longint'(cur) <<< FRAC_BITS;
        prev_f = longint'(prev_state[a]) <<< FRAC_BITS;
        hp_new = coef_product(longint'(hp_state[a]) + cur_f - prev_f, hp_coef_model);
        if (hp_new > VALUE_MAX)
            hp_new = VALUE_MAX;
        else if (hp_new < VALUE_MIN)
            hp_new = VALUE_MIN;
        lp_old        = longint'(lp_state[a]);
        hp_state[a]   = value_t'(hp_new);
        lp_state[a]   = value_t'(lp_old + coef_product(cur_f - lp_old, lp_coef_model));
        prev_state[a] = cur;
        hp_o = hp_state[a];
        lp_o = lp_state[a];
    endfunction

    function automatic filter_out_t filter_step(sample_t x, sample_t y, sample_t z);
        filter_out_t r;
        step_axis(0, x, r.hp_x, r.lp_x);
        step_axis(1, y, r.hp_y, r.lp_y);
        step_axis(2, z, r.hp_z, r.lp_z);
        return r;
    endfunction

    function automatic sample_t pick_sample(int a);
        int mode;
        int delta;
        mode = $urandom_range(9);
        if (mode <= 4)
            return sample_t'($urandom);
        if (mode <= 6)
        begin
            // Slowly moving signal, as a real sensor gives.
            delta   = int'($urandom_range(32)) - 16;
            walk[a] = sample_t'(int'(walk[a]) + delta);
            return walk[a];
        end
        if (mode == 7)
        begin
            case ($urandom_range(3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return SAMPLE_NEG1;
            endcase
        end
        return sample_t'(int'($urandom_range(128)) - 64);
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return COEF_MAX;
            2:       return coef_t'(1);
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic void add_sample(sample_t x, sample_t y, sample_t z);
        stim_row_t r;
        r.kind    = ROW_SAMPLE;
        r.index   = '0;
        r.data    = '0;
        r.x       = x;
        r.y       = y;
        r.z       = z;
        r.checked = 1'b0;
        r.want    = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_checked(sample_t x, sample_t y, sample_t z, filter_out_t want);
        add_sample(x, y, z);
        stim_rows[$].checked = 1'b1;
        stim_rows[$].want    = want;
    endfunction

    function automatic void add_config(cfg_index_t idx, coef_t data);
        stim_row_t r;
        r.kind    = ROW_CONFIG;
        r.index   = idx;
        r.data    = data;
        r.x       = '0;
        r.y       = '0;
        r.z       = '0;
        r.checked = 1'b0;
        r.want    = '0;
        stim_rows.push_back(r);
    endfunction

    task automatic write_register(cfg_index_t idx, coef_t data);
        if (sample_held)
        begin
            sample_if.valid <= 1'b0;
            sample_held = 1'b0;
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_held = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_HIGH_PASS_COEF: hp_coef_model = data;
            CFG_LOW_PASS_COEF:  lp_coef_model = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(sample_t x, sample_t y, sample_t z, bit checked,
                               filter_out_t want);
        filter_out_t predicted;
        if (cfg_held)
        begin
            cfg_if.valid <= 1'b0;
            cfg_held = 1'b0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid    <= 1'b1;
        sample_if.sample_x <= x;
        sample_if.sample_y <= y;
        sample_if.sample_z <= z;
        sample_held = 1'b1;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        predicted = filter_step(x, y, z);
        due_filtered.push_back(checked ? want : predicted);
    endtask

    // Every request gives one result, so an empty queue means the filter is idle.
    task automatic wait_filter_idle();
        if (sample_held)
        begin
            sample_if.valid <= 1'b0;
            sample_held = 1'b0;
        end
        if (cfg_held)
        begin
            cfg_if.valid <= 1'b0;
            cfg_held = 1'b0;
        end
        while (due_filtered.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            result_count++;
            if (due_filtered.size() == 0)
                report_error($sformatf("result %0d arrived with none expected", result_count));
            else
            begin
                want_now       = due_filtered.pop_front();
                got_fields[0]  = result_if.hp_x;
                got_fields[1]  = result_if.hp_y;
                got_fields[2]  = result_if.hp_z;
                got_fields[3]  = result_if.lp_x;
                got_fields[4]  = result_if.lp_y;
                got_fields[5]  = result_if.lp_z;
                want_fields[0] = want_now.hp_x;
                want_fields[1] = want_now.hp_y;
                want_fields[2] = want_now.hp_z;
                want_fields[3] = want_now.lp_x;
                want_fields[4] = want_now.lp_y;
                want_fields[5] = want_now.lp_z;
                for (int i = 0; i < 6; i++)
                begin
                    if (got_fields[i] !== want_fields[i])
                        report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                               result_count, field_names[i],
                                               got_fields[i], want_fields[i]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        sample_if.valid    <= 1'b0;
        sample_if.sample_x <= '0;
        sample_if.sample_y <= '0;
        sample_if.sample_z <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_HIGH_PASS_COEF;
        cfg_if.data        <= '0;
        for (int a = 0; a < 3; a++)
        begin
            hp_state[a]   = '0;
            lp_state[a]   = '0;
            prev_state[a] = '0;
            walk[a]       = '0;
        end

        // Directed part. The first two rows follow straight from the reset state
        // with both coefficients at one half.
        add_checked('0, '0, '0, '0);
        add_checked(SAMPLE_MAX, SAMPLE_MIN, '0,
                    '{hp_x: value_t'(1048448), hp_y: value_t'(-1048576), hp_z: '0,
                      lp_x: value_t'(1048448), lp_y: value_t'(-1048576), lp_z: '0});
        add_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(1));
        add_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        add_sample(SAMPLE_NEG1, SAMPLE_NEG1, SAMPLE_NEG1);
        add_sample('0, '0, SAMPLE_MIN);
        // A zero high-pass coefficient forces the high-pass output to zero.
        add_config(CFG_HIGH_PASS_COEF, '0);
        add_sample(SAMPLE_MAX, SAMPLE_MIN, sample_t'(5));
        // A zero low-pass coefficient freezes the low-pass state.
        add_config(CFG_LOW_PASS_COEF, '0);
        add_sample(sample_t'(1234), sample_t'(-4321), sample_t'(7));
        add_sample(SAMPLE_MIN, SAMPLE_MAX, sample_t'(-7));
        // Largest coefficients with full-scale swings drive the high-pass hardest.
        add_config(CFG_HIGH_PASS_COEF, COEF_MAX);
        add_config(CFG_LOW_PASS_COEF, COEF_MAX);
        add_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        add_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        add_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        add_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        // Writes to indexes past the two registers must change nothing.
        add_config(CFG_FIRST_UNUSED, '0);
        add_config(CFG_LAST_UNUSED, coef_t'(1));
        add_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        add_config(CFG_HIGH_PASS_COEF, coef_t'(1));
        add_config(CFG_LOW_PASS_COEF, coef_t'(1));
        add_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        add_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        add_config(CFG_HIGH_PASS_COEF, HIGH_PASS_COEF_RESET);
        add_config(CFG_LOW_PASS_COEF, LOW_PASS_COEF_RESET);
        add_sample(sample_t'(100), sample_t'(-100), '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CONFIG)
            begin
                wait_filter_idle();
                write_register(stim_rows[i].index, stim_rows[i].data);
            end
            else
                send_sample(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
                            stim_rows[i].checked, stim_rows[i].want);
        end

        // Random part: receiver slow, then sender slow, then full rate.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
            recv_stall_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
            for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++)
            begin
                wait_filter_idle();
                write_register(CFG_HIGH_PASS_COEF, pick_coef());
                write_register(CFG_LOW_PASS_COEF, pick_coef());
                if ($urandom_range(3) == 0)
                    write_register(cfg_index_t'($urandom_range(CFG_LAST_UNUSED,
                                                               CFG_FIRST_UNUSED)),
                                   coef_t'($urandom));
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    send_sample(pick_sample(0), pick_sample(1), pick_sample(2),
                                1'b0, '0);
            end
        end

        wait_filter_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_filtered.size() != 0)
            report_error($sformatf("%0d results never arrived", due_filtered.size()));

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
